// File: rtl/mrc_pkg.sv
// ---------------------------------------------------------------------------
// Mixed-radix code pack/unpack: shared package
// Widths, pipeline geometry and the types passed between the stages.
// ---------------------------------------------------------------------------
package mrc_pkg;

   localparam int DIGITS        = 7;
   localparam int LEVEL_MAX     = 6;
   localparam int NUM_W         = 56;
   localparam int DIGIT_W       = 8;
   localparam int BITS_PER_STEP = 8;
   localparam int STEPS         = NUM_W / BITS_PER_STEP;
   localparam int STAGES        = DIGITS * STEPS;

   localparam logic [2:0] CSR_ALPHABET  = 3'd0;
   localparam logic [2:0] CSR_TOP_LEVEL = 3'd1;

   typedef struct packed {
      logic [DIGIT_W-1:0]                alphabet;
      logic [2:0]                        top_level;
      logic [DIGITS-1:0][DIGIT_W-1:0]    limit;   // entry 0 is always zero
   } cfg_type;

   typedef struct packed {
      logic                              valid;
      logic                              mode;
      logic [2:0]                        len;
      logic                              err;
      logic [2:0]                        rlen;
      logic [NUM_W-1:0]                  acc;
      logic [NUM_W-1:0]                  quo;
      logic [DIGIT_W:0]                  rem;
      logic [DIGITS-1:0][DIGIT_W-1:0]    digit;
   } pipe_type;

endpackage

// File: rtl/mrc_stage.sv
// ---------------------------------------------------------------------------
// Mixed-radix code pack/unpack: pipeline stage
// One register stage. Unpacking divides by the level radix, eight quotient
// bits per stage; packing does one multiply-accumulate in the first step.
// ---------------------------------------------------------------------------
module mrc_stage #(
   parameter int LEVEL_COUNT = mrc_pkg::LEVEL_MAX,
   parameter int UNIT        = 0,
   parameter int STEP        = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  mrc_pkg::cfg_type  cfg,
   input  mrc_pkg::pipe_type pipe_in,
   output mrc_pkg::pipe_type pipe_out
);

   localparam int UNPACK_LEVEL = UNIT;
   localparam int PACK_LEVEL   = mrc_pkg::DIGITS - 1 - UNIT;
   localparam int TOP_BIT      = mrc_pkg::NUM_W - 1 - mrc_pkg::BITS_PER_STEP * STEP;

   mrc_pkg::pipe_type pipe_in_d;
   mrc_pkg::pipe_type pipe_ff;

   // Radix and in-use flag of a level; levels above LEVEL_COUNT have radix zero and are not in use.
   function automatic logic [mrc_pkg::DIGIT_W:0] radix_of(input mrc_pkg::cfg_type c,
                                                          input int lvl);
      logic [mrc_pkg::DIGIT_W:0] r;
      begin
         if (lvl == 0) begin
            r = {1'b0, c.alphabet};
         end else if (lvl <= LEVEL_COUNT) begin
            r = {1'b0, c.limit[lvl]} + 1'b1;
         end else begin
            r = '0;
         end
         return r;
      end
   endfunction

   function automatic logic limit_set(input mrc_pkg::cfg_type c, input int lvl);
      logic s;
      begin
         if (lvl == 0) begin
            s = (c.alphabet != '0);
         end else if (lvl <= LEVEL_COUNT) begin
            s = (c.limit[lvl] != '0);
         end else begin
            s = 1'b0;
         end
         return s;
      end
   endfunction

   logic [mrc_pkg::DIGIT_W:0]   div_radix;
   logic [mrc_pkg::DIGIT_W:0]   pack_radix;
   logic [mrc_pkg::DIGIT_W:0]   rem_w;
   logic [mrc_pkg::DIGIT_W:0]   rem;
   logic [mrc_pkg::NUM_W-1:0]   quo;
   logic [mrc_pkg::DIGIT_W-1:0] pdig;
   logic                        pack_ok;
   logic [mrc_pkg::NUM_W+mrc_pkg::DIGIT_W:0] product;

   always_comb begin
      pipe_in_d  = pipe_in;
      div_radix  = radix_of(cfg, UNPACK_LEVEL);
      pack_radix = radix_of(cfg, PACK_LEVEL);
      pdig       = pipe_in.digit[PACK_LEVEL];
      rem        = (STEP == 0) ? '0 : pipe_in.rem;
      quo        = pipe_in.quo;
      rem_w      = '0;
      pack_ok    = limit_set(cfg, PACK_LEVEL) &&
                   ({1'b0, pdig} < pack_radix);
      product    = pipe_in.acc * pack_radix;
      if (pipe_in.mode) begin
         for (int b = 0; b < mrc_pkg::BITS_PER_STEP; b++) begin
            rem_w = {rem[mrc_pkg::DIGIT_W-1:0], pipe_in.acc[TOP_BIT-b]};
            if (rem_w >= div_radix) begin
               rem              = rem_w - div_radix;
               quo[TOP_BIT-b]   = 1'b1;
            end else begin
               rem              = rem_w;
               quo[TOP_BIT-b]   = 1'b0;
            end
         end
         pipe_in_d.rem = rem;
         pipe_in_d.quo = quo;
         if (STEP == mrc_pkg::STEPS - 1 && limit_set(cfg, UNPACK_LEVEL) &&
             (3'(UNPACK_LEVEL) <= cfg.top_level)) begin
            pipe_in_d.digit[UNPACK_LEVEL] = rem[mrc_pkg::DIGIT_W-1:0];
            pipe_in_d.acc                 = quo;
            if (UNPACK_LEVEL > 0 && rem != '0) begin
               pipe_in_d.rlen = 3'(UNPACK_LEVEL + 1);
            end
         end
      end else if (STEP == 0 && (3'(PACK_LEVEL) < pipe_in.len) && !pipe_in.err) begin
         if (pack_ok) begin
            pipe_in_d.acc = product[mrc_pkg::NUM_W-1:0] +
                            {{(mrc_pkg::NUM_W-mrc_pkg::DIGIT_W){1'b0}}, pdig};
         end else begin
            pipe_in_d.err = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_ff.valid <= 1'b0;
      end else if (advance) begin
         pipe_ff.valid <= pipe_in_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff.mode  <= pipe_in_d.mode;
         pipe_ff.len   <= pipe_in_d.len;
         pipe_ff.err   <= pipe_in_d.err;
         pipe_ff.rlen  <= pipe_in_d.rlen;
         pipe_ff.acc   <= pipe_in_d.acc;
         pipe_ff.quo   <= pipe_in_d.quo;
         pipe_ff.rem   <= pipe_in_d.rem;
         pipe_ff.digit <= pipe_in_d.digit;
      end
   end

   assign pipe_out = pipe_ff;

endmodule

// File: rtl/mixed_radix_code_pack_unpack.sv
// ---------------------------------------------------------------------------
// Mixed-radix code pack/unpack: top level
// Packs a depletion code into one mixed-radix number or takes one apart.
//
//   channel   ports        direction   content
//   request   req_*        in          mode, length, seven digits, number
//   response  rsp_*        out         number, length, seven digits, error
//   control   csr_*        in          register writes, index 0 to 7
//
// The pipeline has seven levels of seven stages; when unpacking, each stage
// produces eight quotient bits of the per-level division. One transfer per
// cycle is sustained while responses are taken. Reset empties the pipeline
// and loads register defaults. When the response is not taken the whole pipeline holds.
// ---------------------------------------------------------------------------
module mixed_radix_code_pack_unpack #(
   parameter int LEVEL_COUNT = mrc_pkg::LEVEL_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [2:0]  req_code_length,
   input  logic [7:0]  req_digit_0,
   input  logic [7:0]  req_digit_1,
   input  logic [7:0]  req_digit_2,
   input  logic [7:0]  req_digit_3,
   input  logic [7:0]  req_digit_4,
   input  logic [7:0]  req_digit_5,
   input  logic [7:0]  req_digit_6,
   input  logic [55:0] req_packed_number,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [55:0] rsp_packed_result,
   output logic [2:0]  rsp_result_length,
   output logic [7:0]  rsp_out_digit_0,
   output logic [7:0]  rsp_out_digit_1,
   output logic [7:0]  rsp_out_digit_2,
   output logic [7:0]  rsp_out_digit_3,
   output logic [7:0]  rsp_out_digit_4,
   output logic [7:0]  rsp_out_digit_5,
   output logic [7:0]  rsp_out_digit_6,
   output logic        rsp_range_error,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   mrc_pkg::cfg_type  cfg_ff;
   mrc_pkg::pipe_type pipe [mrc_pkg::STAGES+1];
   mrc_pkg::pipe_type last;
   logic              advance;
   logic              keep_pack;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alphabet  <= 8'd2;
         cfg_ff.top_level <= '0;
         cfg_ff.limit     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mrc_pkg::CSR_ALPHABET:  cfg_ff.alphabet  <= csr_write_data;
            mrc_pkg::CSR_TOP_LEVEL: cfg_ff.top_level <= csr_write_data[2:0];
            default:                cfg_ff.limit[csr_index - 3'd1] <= csr_write_data;
         endcase
      end
   end

   assign advance   = !pipe[mrc_pkg::STAGES].valid || rsp_ready;
   assign req_ready = advance;

   always_comb begin
      pipe[0].valid = req_valid;
      pipe[0].mode  = req_mode;
      pipe[0].len   = req_code_length;
      // A code longer than the set allows is rejected before any level.
      pipe[0].err   = !req_mode &&
                      ({1'b0, req_code_length} > ({1'b0, cfg_ff.top_level} + 4'd1));
      pipe[0].rlen  = req_mode ? 3'd1 : 3'd0;
      pipe[0].acc   = req_mode ? req_packed_number : '0;
      pipe[0].quo   = '0;
      pipe[0].rem   = '0;
      if (req_mode) begin
         pipe[0].digit = '0;
      end else begin
         pipe[0].digit = {req_digit_6, req_digit_5, req_digit_4, req_digit_3,
                          req_digit_2, req_digit_1, req_digit_0};
      end
   end

   for (genvar u = 0; u < mrc_pkg::DIGITS; u++) begin : g_unit
      for (genvar s = 0; s < mrc_pkg::STEPS; s++) begin : g_step
         mrc_stage #(
            .LEVEL_COUNT (LEVEL_COUNT),
            .UNIT        (u),
            .STEP        (s)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .advance  (advance),
            .cfg      (cfg_ff),
            .pipe_in  (pipe[u*mrc_pkg::STEPS+s]),
            .pipe_out (pipe[u*mrc_pkg::STEPS+s+1])
         );
      end
   end

   assign last      = pipe[mrc_pkg::STAGES];
   assign keep_pack = !last.mode && !last.err;

   assign rsp_valid         = last.valid;
   assign rsp_packed_result = keep_pack ? last.acc : '0;
   assign rsp_result_length = last.rlen;
   assign rsp_range_error   = !last.mode && last.err;
   assign rsp_out_digit_0   = last.mode ? last.digit[0] : '0;
   assign rsp_out_digit_1   = last.mode ? last.digit[1] : '0;
   assign rsp_out_digit_2   = last.mode ? last.digit[2] : '0;
   assign rsp_out_digit_3   = last.mode ? last.digit[3] : '0;
   assign rsp_out_digit_4   = last.mode ? last.digit[4] : '0;
   assign rsp_out_digit_5   = last.mode ? last.digit[5] : '0;
   assign rsp_out_digit_6   = last.mode ? last.digit[6] : '0;

endmodule
